>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define B2DA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define B2DA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `B2DA_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `B2DA_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> hdl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int IN_W           = 64;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Decimal digits needed for an n-bit unsigned value: floor(n*log10(2)) + 1.
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> hdl/b2da_digit_cell.sv
// One BCD digit of the double dabble chain; also shifts digits toward the output.
// Depends on b2da_pkg.
module b2da_digit_cell
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               carry_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit_out = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

>>> hdl/binary_to_decimal_ascii.sv
// Top level: unsigned binary to decimal ASCII digits, most significant first.
// Depends on b2da_pkg and b2da_digit_cell.
//
//  channel   signals                       direction  payload
//  input     in_valid / in_ready           in         value[63:0]
//  output    out_valid / out_ready         out        digit_char[5:0], last
//
// One value at a time. After acceptance the digit chain runs double
// dabble over all VALUE_BITS input bits, then ST_SKIP drops up to
// NUM_DIGITS-1 leading zeros, then one digit goes out per accepted
// output transaction.
// Output stalls hold the chain; in_ready is high only while idle.
// Reset clears the controller and the digit chain.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IN_W-1:0]   value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last
);

    localparam int NUM_DIGITS = num_digits(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    cell_ctrl_t             ctrl;

    logic [NUM_DIGITS-1:0]  carry;
    logic [DIGIT_W-1:0]     digits [NUM_DIGITS];
    logic [DIGIT_W-1:0]     top_digit;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                b2da_digit_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .carry_in  (value_reg[VALUE_BITS-1]),
                    .digit_in  ({DIGIT_W{1'b0}}),
                    .carry_out (carry[gi]),
                    .digit_out (digits[gi])
                );
            end
            else
            begin : g_rest
                b2da_digit_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .carry_in  (carry[gi-1]),
                    .digit_in  (digits[gi-1]),
                    .carry_out (carry[gi]),
                    .digit_out (digits[gi])
                );
            end
        end
    endgenerate

    assign top_digit  = digits[NUM_DIGITS-1];
    assign digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
    assign last       = (rem_reg == REM_ONE);

    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        ctrl        = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    value_next = value[VALUE_BITS-1:0];
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                ctrl.dabble = 1'b1;
                value_next  = {value_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    rem_next   = REM_FULL;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && rem_reg != REM_ONE)
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    if (rem_reg == REM_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> hdl/b2da_checker.sv
// Port-level checks for binary_to_decimal_ascii, attached by bind.
// Depends on b2da_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b2da_checker
    import b2da_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] digit_char,
    input logic              last
);

    `B2DA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(digit_char) && $stable(last), "stalled digit changed")
    `B2DA_ASSERT_IMPL(a_digit_range, clk, rst_n, out_valid,
        digit_char >= 6'd48 && digit_char <= 6'd57, "digit_char outside 0-9")
    `B2DA_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_valid && in_ready,
        !out_valid, "input taken while digits pending")
    `B2DA_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && last,
        !out_valid && in_ready, "output continued after last digit")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
);
